// ===== sv/pmt_pkg.sv =====
package pmt_pkg;

   localparam int TIC_W    = 31;
   localparam int ID_W     = 16;
   localparam int DAMAGE_W = 16;
   localparam int ROLL_W   = 10;
   localparam int LIMIT_W  = 16;
   localparam int DESYNC_W = 32;
   localparam int PEND_W   = 6;

   typedef enum logic [1:0] {
      OP_RECORD   = 2'd0,
      OP_VALIDATE = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_TICK     = 2'd3
   } opcode_type;

   // one table entry as held in the entry memory
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [DAMAGE_W-1:0] damage;
      logic                critical;
      logic [ROLL_W-1:0]   roll;
      logic [TIC_W-1:0]    tick;
   } entry_type;

   typedef struct packed {
      logic scan_start;   // rewind scan, clear per-item result flags
      logic clear_all;    // drop every pending mark
      logic rec_step;     // record: test one slot, write when settled
      logic issue;        // scan: read entry at scan index
      logic eval;         // scan: evaluate the entry read last cycle
      logic load_rsp;     // move result into the output register
   } dp_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       aging;
      logic       rec_done;
      logic       issue_done;
      logic       scan_done;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== sv/pmt_ctrl.sv =====
module pmt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pmt_pkg::dp_status_type status,
   output pmt_pkg::dp_cmd_type    cmd
);
   import pmt_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DISPATCH = 5'b00010,
      ST_RECORD   = 5'b00100,
      ST_SCAN     = 5'b01000,
      ST_FINISH   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            cmd.scan_start = 1'b1;
            case (status.op)
               OP_RECORD:   state_in = ST_RECORD;
               OP_VALIDATE: state_in = ST_SCAN;
               OP_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  state_in      = ST_FINISH;
               end
               OP_TICK:     state_in = status.aging ? ST_SCAN : ST_FINISH;
               default:     state_in = ST_FINISH;
            endcase
         end
         ST_RECORD: begin
            cmd.rec_step = 1'b1;
            if (status.rec_done) state_in = ST_FINISH;
         end
         ST_SCAN: begin
            cmd.issue = !status.issue_done;
            cmd.eval  = 1'b1;
            if (status.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== sv/pmt_dp.sv =====
module pmt_dp #(
   parameter int ENTRIES = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pmt_pkg::dp_cmd_type              cmd,
   output pmt_pkg::dp_status_type           status,
   input  logic                             req_accept,
   input  pmt_pkg::opcode_type              req_op,
   input  logic [pmt_pkg::TIC_W-1:0]        req_tic,
   input  logic [pmt_pkg::ID_W-1:0]         req_lookup_id,
   input  logic [pmt_pkg::DAMAGE_W-1:0]     req_damage,
   input  logic                             req_critical,
   input  logic [pmt_pkg::ROLL_W-1:0]       req_roll,
   input  logic                             aging_enable,
   input  logic [pmt_pkg::LIMIT_W-1:0]      age_limit,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [pmt_pkg::ID_W-1:0]         rsp_assigned_id,
   output logic                             rsp_found,
   output logic                             rsp_mismatch,
   output logic [pmt_pkg::PEND_W-1:0]       rsp_pending_total,
   output logic [pmt_pkg::DESYNC_W-1:0]     rsp_desync_total
);
   import pmt_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

   // entry memory: one write port, one registered read port
   entry_type entry_mem [ENTRIES];

   // latched item
   opcode_type          op_ff;
   logic [TIC_W-1:0]    tic_ff;
   logic [ID_W-1:0]     lid_ff;
   logic [DAMAGE_W-1:0] dmg_ff;
   logic                crit_ff;
   logic [ROLL_W-1:0]   roll_ff;

   logic [ENTRIES-1:0]  pending_ff, pending_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [ID_W-1:0]     next_id_ff;
   logic [IW-1:0]       slot_ptr_ff;   // next_id mod ENTRIES, tracked incrementally
   logic [DESYNC_W-1:0] desync_ff;

   logic [IW-1:0]       idx_ff;
   logic                issue_done_ff;
   logic                rd_valid_ff;
   logic [IW-1:0]       rd_idx_ff;
   entry_type           rd_data_ff;

   logic [ID_W-1:0]     assigned_ff;
   logic                found_ff;
   logic                mism_ff;

   logic                rsp_valid_ff;
   logic [ID_W-1:0]     rsp_assigned_ff;
   logic                rsp_found_ff;
   logic                rsp_mism_ff;
   logic [PEND_W-1:0]   rsp_pending_ff;
   logic [DESYNC_W-1:0] rsp_desync_ff;

   logic                free;
   logic                idx_last;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   entry_type           wr_data;
   logic                eval_ok;
   logic                rd_pend;
   logic                hit;
   logic                differ;
   logic [TIC_W-1:0]    age;
   logic                expire;
   logic                eval_last;
   logic [CW+PEND_W-1:0] count_ext;

   always_comb begin
      free     = !pending_ff[idx_ff];
      idx_last = (idx_ff == LAST);
      // take the first free slot, else the id-selected one after the last slot
      wr_en    = cmd.rec_step && (free || idx_last);
      wr_addr  = free ? idx_ff : slot_ptr_ff;
      wr_data.id       = next_id_ff;
      wr_data.damage   = dmg_ff;
      wr_data.critical = crit_ff;
      wr_data.roll     = roll_ff;
      wr_data.tick     = tic_ff;

      eval_ok = cmd.eval && rd_valid_ff;
      rd_pend = pending_ff[rd_idx_ff];
      hit     = eval_ok && (op_ff == OP_VALIDATE) && rd_pend && (rd_data_ff.id == lid_ff);
      differ  = (rd_data_ff.damage != dmg_ff) || (rd_data_ff.critical != crit_ff) ||
                (rd_data_ff.roll != roll_ff);
      age     = tic_ff - rd_data_ff.tick;
      // entries stamped ahead of now never expire
      expire  = eval_ok && (op_ff == OP_TICK) && rd_pend && (tic_ff >= rd_data_ff.tick) &&
                (age > {{(TIC_W-LIMIT_W){1'b0}}, age_limit});
      eval_last = rd_valid_ff && (rd_idx_ff == LAST);

      pending_in = pending_ff;
      count_in   = count_ff;
      if (cmd.clear_all) begin
         pending_in = '0;
         count_in   = '0;
      end else if (wr_en) begin
         pending_in[wr_addr] = 1'b1;
         if (free) count_in = count_ff + 1'b1;
      end else if (expire) begin
         pending_in[rd_idx_ff] = 1'b0;
         count_in = count_ff - 1'b1;
      end

      count_ext = {{PEND_W{1'b0}}, count_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
      if (cmd.issue) rd_data_ff <= entry_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_op;
         tic_ff  <= req_tic;
         lid_ff  <= req_lookup_id;
         dmg_ff  <= req_damage;
         crit_ff <= req_critical;
         roll_ff <= req_roll;
      end
      if (cmd.issue) rd_idx_ff <= idx_ff;
      if (cmd.load_rsp) begin
         rsp_assigned_ff <= assigned_ff;
         rsp_found_ff    <= found_ff;
         rsp_mism_ff     <= mism_ff;
         rsp_pending_ff  <= count_ext[PEND_W-1:0];
         rsp_desync_ff   <= desync_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         count_ff      <= '0;
         next_id_ff    <= '0;
         slot_ptr_ff   <= '0;
         desync_ff     <= '0;
         idx_ff        <= '0;
         issue_done_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         assigned_ff   <= '0;
         found_ff      <= 1'b0;
         mism_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         count_ff    <= count_in;
         rd_valid_ff <= cmd.issue;

         if (cmd.scan_start) begin
            idx_ff        <= '0;
            issue_done_ff <= 1'b0;
            assigned_ff   <= '0;
            found_ff      <= 1'b0;
            mism_ff       <= 1'b0;
         end else if ((cmd.rec_step && !wr_en) || cmd.issue) begin
            if (idx_last) issue_done_ff <= 1'b1;
            else          idx_ff <= idx_ff + 1'b1;
         end

         if (wr_en) begin
            assigned_ff <= next_id_ff;
            next_id_ff  <= next_id_ff + 1'b1;
            // id wraps to zero, and zero mod ENTRIES is zero
            if (next_id_ff == {ID_W{1'b1}} || slot_ptr_ff == LAST) slot_ptr_ff <= '0;
            else slot_ptr_ff <= slot_ptr_ff + 1'b1;
         end

         if (hit) begin
            found_ff <= 1'b1;
            mism_ff  <= differ;
            if (differ) desync_ff <= desync_ff + 1'b1;
         end

         if (cmd.load_rsp)  rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.op         = op_ff;
      status.aging      = aging_enable;
      status.rec_done   = free || idx_last;
      status.issue_done = issue_done_ff;
      status.scan_done  = hit || eval_last;
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_assigned_id   = rsp_assigned_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_mismatch      = rsp_mism_ff;
   assign rsp_pending_total = rsp_pending_ff;
   assign rsp_desync_total  = rsp_desync_ff;

endmodule

// ===== sv/prediction_match_table.sv =====
// Prediction match table.
// Input stream (req_): one transfer per item, opcode in tuser selects record,
// validate, clear or tick; the other fields travel in tdata. Every item gives
// exactly one result transfer on the rsp_ stream, in order.
// Config (csr_): APB-style, aging_enable at 0x0, age_limit at 0x4; write only
// while the table is idle.
// Every item passes a dispatch step, then record walks the slots up to the
// first free one (the whole table when full), validate and tick with aging
// on scan the entries until a hit or the last entry, and a finish step loads
// the output register. Items are handled one at a time: the table walks its
// entries one per cycle through the single read port of the entry memory.
// A finished result sits in an output register; the next item is accepted
// while it waits, and only the final step of that item stalls until the
// receiver takes the pending result.
// Reset: all pending marks clear, id counter and desync counter zero,
// aging off, age limit 64. Entry contents are not cleared; only pending
// entries are ever evaluated.
module prediction_match_table #(
   parameter int ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   // req stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [30:0] current_tic, [46:31] lookup_id, [62:47] damage, [63] critical,
   // [73:64] roll value, [79:74] zero
   input  logic [79:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]  req_tuser,
   // rsp stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] assigned_id, [16] found, [17] mismatch, [23:18] pending_total,
   // [55:24] desync_total
   output logic [55:0] rsp_tdata,
   // config port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pmt_pkg::*;

   localparam logic REG_AGING_ENABLE = 1'b0;
   localparam logic REG_AGE_LIMIT    = 1'b1;

   logic               aging_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               csr_wr;
   logic               req_accept;
   dp_cmd_type         cmd;
   dp_status_type      status;

   logic [ID_W-1:0]     rsp_assigned_id;
   logic                rsp_found;
   logic                rsp_mismatch;
   logic [PEND_W-1:0]   rsp_pending_total;
   logic [DESYNC_W-1:0] rsp_desync_total;

   // config registers; address bit 2 picks the register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         aging_ff <= 1'b0;
         limit_ff <= LIMIT_W'(64);
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_AGING_ENABLE: aging_ff <= csr_pwdata[0];
            REG_AGE_LIMIT:    limit_ff <= csr_pwdata[LIMIT_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_AGING_ENABLE: csr_prdata = {31'b0, aging_ff};
         REG_AGE_LIMIT:    csr_prdata = {{(32-LIMIT_W){1'b0}}, limit_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   pmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pmt_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_accept        (req_accept),
      .req_op            (opcode_type'(req_tuser)),
      .req_tic           (req_tdata[30:0]),
      .req_lookup_id     (req_tdata[46:31]),
      .req_damage        (req_tdata[62:47]),
      .req_critical      (req_tdata[63]),
      .req_roll          (req_tdata[73:64]),
      .aging_enable      (aging_ff),
      .age_limit         (limit_ff),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_found         (rsp_found),
      .rsp_mismatch      (rsp_mismatch),
      .rsp_pending_total (rsp_pending_total),
      .rsp_desync_total  (rsp_desync_total)
   );

   assign rsp_tdata = {rsp_desync_total, rsp_pending_total, rsp_mismatch, rsp_found,
                       rsp_assigned_id};

   // an accepted item keeps the input closed until its result is produced
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("input still open after accepting an item");

   // a loaded result is offered on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_tvalid)
      else $error("loaded result not presented");

   // record stepping and scan reads never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.rec_step && (cmd.issue || cmd.eval)))
      else $error("record and scan commands together");

   // only validate reports found or mismatch, and mismatch implies found
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[17] || rsp_tdata[16]))
      else $error("mismatch without a found entry");

   // pending count stays within the table size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((ENTRIES >= 64) || (rsp_tdata[23:18] <= 6'(ENTRIES))))
      else $error("pending count exceeds table size");

endmodule

// ===== test/prediction_match_table_checker.sv =====
`timescale 1ns / 1ps

package pmt_test_pkg;
   import pmt_pkg::*;

   // register byte addresses on the csr_ port
   localparam logic [2:0] CSR_AGING_ENABLE = 3'd0;
   localparam logic [2:0] CSR_AGE_LIMIT    = 3'd4;

   // req_tdata layout, lowest field last
   typedef struct packed {
      logic [5:0]          pad;
      logic [ROLL_W-1:0]   roll;
      logic                critical;
      logic [DAMAGE_W-1:0] damage;
      logic [ID_W-1:0]     lookup_id;
      logic [TIC_W-1:0]    current_tic;
   } table_request_type;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [DESYNC_W-1:0] desync_total;
      logic [PEND_W-1:0]   pending_total;
      logic                mismatch;
      logic                found;
      logic [ID_W-1:0]     assigned_id;
   } table_result_type;

endpackage

module prediction_match_table_checker #(
   parameter int ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          open_count,
   output int          checked_count,
   output int          hit_count,
   output int          desync_seen,
   output int          aged_count,
   output int          overwrite_count
);
   import pmt_pkg::*;
   import pmt_test_pkg::*;

   // shadow table
   logic                held          [ENTRIES];
   logic [ID_W-1:0]     held_id       [ENTRIES];
   logic [DAMAGE_W-1:0] held_damage   [ENTRIES];
   logic                held_critical [ENTRIES];
   logic [ROLL_W-1:0]   held_roll     [ENTRIES];
   logic [TIC_W-1:0]    held_tick     [ENTRIES];
   logic [ID_W-1:0]     id_counter;
   logic [DESYNC_W-1:0] desync_counter;
   logic                aging_on;
   logic [LIMIT_W-1:0]  age_window;

   table_result_type due_results[$];

   task automatic predict_table_step(input opcode_type op, input table_request_type rq,
                                     output table_result_type res);
      int          slot;
      int          live;
      logic [31:0] age;
      res = '0;
      case (op)
         OP_RECORD: begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (!held[i] && slot < 0)
                  slot = i;
            if (slot < 0) begin
               slot = int'(id_counter) % ENTRIES;
               overwrite_count++;
            end
            held[slot]          = 1'b1;
            held_id[slot]       = id_counter;
            held_damage[slot]   = rq.damage;
            held_critical[slot] = rq.critical;
            held_roll[slot]     = rq.roll;
            held_tick[slot]     = rq.current_tic;
            res.assigned_id     = id_counter;
            id_counter          = id_counter + 1'b1;
         end
         OP_VALIDATE: begin
            // lowest matching slot wins; entry stays pending
            for (int i = 0; i < ENTRIES; i++) begin
               if (!res.found && held[i] && held_id[i] == rq.lookup_id) begin
                  res.found = 1'b1;
                  hit_count++;
                  if (held_damage[i] != rq.damage || held_critical[i] != rq.critical ||
                      held_roll[i] != rq.roll) begin
                     res.mismatch   = 1'b1;
                     desync_counter = desync_counter + 1'b1;
                     desync_seen++;
                  end
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++)
               held[i] = 1'b0;
         end
         default: begin
            if (aging_on) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  age = {1'b0, rq.current_tic} - {1'b0, held_tick[i]};
                  if (held[i] && rq.current_tic >= held_tick[i] &&
                      age > {16'b0, age_window}) begin
                     held[i] = 1'b0;
                     aged_count++;
                  end
               end
            end
         end
      endcase
      live = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (held[i])
            live++;
      res.pending_total = live[PEND_W-1:0];
      res.desync_total  = desync_counter;
   endtask

   always @(posedge clock) begin : watch
      table_result_type got;
      table_result_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++)
            held[i] = 1'b0;
         id_counter     = '0;
         desync_counter = '0;
         aging_on       = 1'b0;
         age_window     = 16'd64;
         due_results.delete();
         open_count     = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               CSR_AGING_ENABLE: aging_on   = csr_pwdata[0];
               CSR_AGE_LIMIT:    age_window = csr_pwdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = table_result_type'(rsp_tdata);
            if (due_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%t: unexpected result transfer, data %h", $realtime, rsp_tdata);
            end else begin
               want = due_results.pop_front();
               checked_count++;
               if (got.assigned_id !== want.assigned_id || got.found !== want.found ||
                   got.mismatch !== want.mismatch ||
                   got.pending_total !== want.pending_total ||
                   got.desync_total !== want.desync_total) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%t: result %0d: expected id %h found %b mism %b pend %0d %s %0d",
                              $realtime, checked_count, want.assigned_id, want.found,
                              want.mismatch, want.pending_total, "desync",
                              want.desync_total,
                              "\n            got      id %h found %b mism %b pend %0d desync %0d",
                              got.assigned_id, got.found, got.mismatch, got.pending_total,
                              got.desync_total);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_table_step(opcode_type'(req_tuser), table_request_type'(req_tdata), want);
            due_results.push_back(want);
         end
         open_count = due_results.size();
      end
   end

endmodule

// ===== test/prediction_match_table_test.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the prediction match table. The checker beside
// the DUT predicts every result; this module only drives the three ports.
module prediction_match_table_test;
   import pmt_pkg::*;
   import pmt_test_pkg::*;

   localparam int ENTRIES     = 32;
   localparam int RECENT_KEEP = 48;
   // whole run is well under 3 ms; this is the hang guard
   localparam int RUN_LIMIT_NS = 20_000_000;

   typedef struct {
      logic [ID_W-1:0]     id;
      logic [DAMAGE_W-1:0] damage;
      logic                critical;
      logic [ROLL_W-1:0]   roll;
   } prediction_note_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b1;
   logic [55:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count, open_count, checked_count;
   int hit_count, desync_seen, aged_count, overwrite_count;

   // stimulus bookkeeping
   int                  op_count [4];
   int                  record_count = 0;   // also the id the next record gets
   int                  burst_left   = 0;
   logic [TIC_W-1:0]    game_tic;
   prediction_note_type recent_predictions[$];

   // receiver stall pattern state
   logic [15:0] stall_pattern = 16'hFFFF;
   int          pattern_left  = 0;

   always #2 clock = ~clock;

   prediction_match_table #(
      .ENTRIES(ENTRIES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   prediction_match_table_checker #(
      .ENTRIES(ENTRIES)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .open_count     (open_count),
      .checked_count  (checked_count),
      .hit_count      (hit_count),
      .desync_seen    (desync_seen),
      .aged_count     (aged_count),
      .overwrite_count(overwrite_count)
   );

   // Receiver: a 16-bit ready pattern rotated every cycle, reloaded after a
   // random stretch. Patterns: always ready, random, single holes, full stall.
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         pattern_left = $urandom_range(8, 64);
         case ($urandom_range(0, 3))
            0:       stall_pattern = 16'hFFFF;
            1:       stall_pattern = 16'($urandom);
            2:       stall_pattern = 16'hFFFF ^ (16'h1 << $urandom_range(0, 15));
            default: stall_pattern = 16'h0000;
         endcase
      end
      pattern_left--;
      rsp_tready    = stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
   end

   function automatic table_request_type make_request(input logic [TIC_W-1:0] tic,
                                                      input logic [ID_W-1:0] lid,
                                                      input logic [DAMAGE_W-1:0] dmg,
                                                      input logic crit,
                                                      input logic [ROLL_W-1:0] roll);
      table_request_type rq;
      rq.pad         = '0;
      rq.current_tic = tic;
      rq.lookup_id   = lid;
      rq.damage      = dmg;
      rq.critical    = crit;
      rq.roll        = roll;
      return rq;
   endfunction

   function automatic table_request_type noise_request();
      return make_request(TIC_W'($urandom), ID_W'($urandom), DAMAGE_W'($urandom),
                          1'($urandom), ROLL_W'($urandom));
   endfunction

   // Random fields except for the tick.
   function automatic table_request_type tick_request(input logic [TIC_W-1:0] tic);
      table_request_type rq;
      rq             = noise_request();
      rq.current_tic = tic;
      return rq;
   endfunction

   // One transfer on req_. The sender runs in bursts with a random idle gap
   // ahead of each burst. Valid stays high between back-to-back items so only
   // one write per signal lands in a step.
   task automatic send_item(input opcode_type op, input table_request_type rq);
      int                  gap;
      prediction_note_type note;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
      end
      burst_left--;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = rq;
      do @(posedge clock); while (!req_tready);
      op_count[op]++;
      if (op == OP_RECORD) begin
         note.id       = ID_W'(record_count);
         note.damage   = rq.damage;
         note.critical = rq.critical;
         note.roll     = rq.roll;
         recent_predictions.push_back(note);
         if (recent_predictions.size() > RECENT_KEEP)
            void'(recent_predictions.pop_front());
         record_count++;
      end
   endtask

   // Drop valid and wait until every result has come back.
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Reprogram both registers with the table idle. Unused upper bits of
   // the write data carry junk half the time.
   task automatic configure(input logic aging, input logic [LIMIT_W-1:0] limit);
      logic [31:0] junk;
      settle();
      junk = $urandom_range(0, 1) ? $urandom : 32'h0;
      csr_write(CSR_AGING_ENABLE, (junk & ~32'h1) | {31'b0, aging});
      csr_write(CSR_AGE_LIMIT, (junk & 32'hFFFF_0000) | {16'b0, limit});
   endtask

   // Mostly well-formed traffic: ticks near a slowly advancing game clock,
   // validates of ids recorded recently (exact, one bit off, or garbage),
   // plus a share of off-clock tics and unknown ids.
   task automatic random_item(input int clear_pct, input int tick_pct);
      table_request_type   rq;
      prediction_note_type note;
      opcode_type          op;
      int                  pick;
      rq = noise_request();
      game_tic = TIC_W'(game_tic + $urandom_range(0, 3));
      if ($urandom_range(0, 19) == 0)
         game_tic = TIC_W'(game_tic + $urandom_range(0, 80000));
      pick = $urandom_range(0, 99);
      if (pick < clear_pct)
         op = OP_CLEAR;
      else if (pick < clear_pct + tick_pct)
         op = OP_TICK;
      else if ($urandom_range(0, 99) < 55)
         op = OP_RECORD;
      else
         op = OP_VALIDATE;
      if ((op == OP_RECORD || op == OP_TICK) && $urandom_range(0, 9) != 0)
         rq.current_tic = TIC_W'(game_tic - $urandom_range(0, 4));
      if (op == OP_RECORD) begin
         case ($urandom_range(0, 7))
            0: rq.damage = '0;
            1: rq.damage = '1;
            default: ;
         endcase
         case ($urandom_range(0, 7))
            0: rq.roll = '0;
            1: rq.roll = '1;
            default: ;
         endcase
      end
      if (op == OP_VALIDATE && recent_predictions.size() != 0 && $urandom_range(0, 4) != 0)
      begin
         note = recent_predictions[$urandom_range(0, recent_predictions.size() - 1)];
         rq.lookup_id = note.id;
         case ($urandom_range(0, 3))
            0, 1: begin
               rq.damage   = note.damage;
               rq.critical = note.critical;
               rq.roll     = note.roll;
            end
            2: begin
               // one field off by a single bit
               rq.damage   = note.damage;
               rq.critical = note.critical;
               rq.roll     = note.roll;
               case ($urandom_range(0, 2))
                  0:       rq.damage   = rq.damage ^ (16'h1 << $urandom_range(0, 15));
                  1:       rq.critical = ~rq.critical;
                  default: rq.roll     = rq.roll ^ (10'h1 << $urandom_range(0, 9));
               endcase
            end
            default: ;
         endcase
      end
      send_item(op, rq);
   endtask

   // One stretch of random traffic under a fresh register setting. The mix
   // is either table filling (overwrites when full), churn with clears, or
   // tick heavy.
   task automatic run_segment(input int length);
      int                 clear_pct;
      int                 tick_pct;
      logic               aging;
      logic [LIMIT_W-1:0] limit;
      case ($urandom_range(0, 2))
         0:       begin clear_pct = 0; tick_pct = 5;  end
         1:       begin clear_pct = 8; tick_pct = 15; end
         default: begin clear_pct = 2; tick_pct = 35; end
      endcase
      aging = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0:       limit = '0;
         1:       limit = '1;
         2:       limit = LIMIT_W'($urandom_range(41, 65534));
         default: limit = LIMIT_W'($urandom_range(1, 40));
      endcase
      configure(aging, limit);
      repeat (length) random_item(clear_pct, tick_pct);
   endtask

   initial begin
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      game_tic = TIC_W'($urandom_range(0, 1000));
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed: reset settings (aging off, limit 64) ---
      // lookups into an empty table, both id extremes
      send_item(OP_VALIDATE, make_request('0, '0, '0, 1'b0, '0));
      send_item(OP_VALIDATE, make_request('1, '1, '1, 1'b1, '1));
      // tick with aging off changes nothing
      send_item(OP_TICK, tick_request('1));
      // records at the field extremes: ids 0 and 1
      send_item(OP_RECORD, make_request('0, ID_W'($urandom), '0, 1'b0, '0));
      send_item(OP_RECORD, make_request('1, ID_W'($urandom), '1, 1'b1, '1));
      send_item(OP_VALIDATE, make_request(TIC_W'($urandom), 16'd0, '0, 1'b0, '0));
      // each field differing on its own; entry stays pending every time
      send_item(OP_VALIDATE, make_request(TIC_W'($urandom), 16'd1, 16'hFFFE, 1'b1, '1));
      send_item(OP_VALIDATE, make_request(TIC_W'($urandom), 16'd1, '1, 1'b0, '1));
      send_item(OP_VALIDATE, make_request(TIC_W'($urandom), 16'd1, '1, 1'b1, 10'h3FE));
      send_item(OP_VALIDATE, make_request(TIC_W'($urandom), 16'd1, '1, 1'b1, '1));
      send_item(OP_TICK, tick_request('1));
      // clear keeps id and desync counters; old id then misses
      send_item(OP_CLEAR, noise_request());
      send_item(OP_VALIDATE, make_request(TIC_W'($urandom), 16'd1, '1, 1'b1, '1));

      // aging on, zero limit: equal tick survives, one later expires,
      // an entry stamped ahead of now never expires
      configure(1'b1, '0);
      send_item(OP_RECORD, make_request(31'd100, ID_W'($urandom), 16'h00A5, 1'b0, 10'h2AA));
      send_item(OP_RECORD, make_request(31'd200, ID_W'($urandom), 16'h1234, 1'b1, 10'h155));
      send_item(OP_TICK, tick_request(31'd100));
      send_item(OP_TICK, tick_request(31'd101));
      send_item(OP_VALIDATE, make_request(TIC_W'($urandom), 16'd2, 16'h00A5, 1'b0, 10'h2AA));
      send_item(OP_VALIDATE, make_request(TIC_W'($urandom), 16'd3, 16'h1234, 1'b1, 10'h155));

      // limit 10: boundary at exactly the limit and one past it
      configure(1'b1, 16'd10);
      send_item(OP_RECORD, tick_request(31'd1000));
      send_item(OP_TICK, tick_request(31'd1010));
      send_item(OP_TICK, tick_request(31'd1011));

      // widest limit at the top of the tick range
      configure(1'b1, '1);
      send_item(OP_RECORD, make_request(31'h7FFF_0000, ID_W'($urandom), 16'h5A5A, 1'b1,
                                        10'h0F0));
      send_item(OP_TICK, tick_request('1));
      send_item(OP_VALIDATE, make_request(TIC_W'($urandom), 16'd5, 16'h5A5A, 1'b1, 10'h0F0));

      // --- random traffic ---
      repeat (8) run_segment(72);

      settle();
      repeat (ENTRIES + 8) @(negedge clock);

      $display("Sent %0d items (%0d record, %0d validate, %0d clear, %0d tick), %0d results checked",
               op_count[OP_RECORD] + op_count[OP_VALIDATE] + op_count[OP_CLEAR] +
               op_count[OP_TICK], op_count[OP_RECORD], op_count[OP_VALIDATE],
               op_count[OP_CLEAR], op_count[OP_TICK], checked_count);
      $display("%0d lookup hits, %0d desyncs, %0d entries aged out, %0d full-table records",
               hit_count, desync_seen, aged_count, overwrite_count);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
